// ----- hw/rtl/crc32gc_pkg.sv -----
// Shared types, constants and CRC-32 helper functions for the CRC-32 generate/check block.
// The package stands alone; every RTL module of the block imports it.
`default_nettype none

package crc32gc_pkg;

   localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [7:0]  BYTE_MSB   = 8'h80;
   localparam logic [7:0]  BYTE_ONES  = 8'hFF;
   localparam int          TAIL_BYTES = 4;
   localparam int          COUNT_W    = $clog2(TAIL_BYTES);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] crc_value;
      logic        crc_error;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] reg_in, input logic [7:0] byte_in);
      logic [31:0] acc;
      logic        fb;
      acc = reg_in;
      for (int i = 7; i >= 0; i--) begin
         fb  = byte_in[i] ^ acc[31];
         acc = {acc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
      end
      return acc;
   endfunction

   // Inverting the last k bytes of a frame changes the final register by the CRC of k
   // bytes of all ones run from a zero register.
   function automatic logic [31:0] tail_delta(input int k);
      logic [31:0] acc;
      acc = 32'h0;
      for (int i = 0; i < k; i++) begin
         acc = crc_byte(acc, BYTE_ONES);
      end
      return acc;
   endfunction

   localparam logic [31:0] TAIL_DELTA [TAIL_BYTES] = '{
      tail_delta(1), tail_delta(2), tail_delta(3), tail_delta(4)
   };

endpackage

`default_nettype wire

// ----- hw/rtl/crc32gc_in_reg.sv -----
// Input register stage of the CRC-32 block: holds one request transaction.
// Depends on crc32gc_pkg for the request payload type.
`default_nettype none

module crc32gc_in_reg
   import crc32gc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         s1_valid,
   output req_type      s1_data,
   input  wire logic    s1_take
);

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    load;

   assign load      = req_valid && (!valid_ff || s1_take);
   assign req_stall = valid_ff && !s1_take;
   assign valid_in  = load || (valid_ff && !s1_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/crc32gc_core.sv -----
// CRC update, frame state and result register of the CRC-32 block.
// Depends on crc32gc_pkg for payload types, the byte update function and tail constants.
`default_nettype none

module crc32gc_core
   import crc32gc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   input  wire logic    s1_valid,
   input  wire req_type s1_data,
   output logic         s1_take,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic               mode_ff, mode_in;
   logic [31:0]        crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff;
   logic [31:0]        next_crc;
   logic [31:0]        residual;
   logic               finish;

   assign s1_take  = s1_valid && (!s1_data.last_byte || !out_valid_ff || !rsp_stall);
   assign finish   = s1_take && s1_data.last_byte;
   assign next_crc = crc_byte(crc_ff, s1_data.data_byte);
   assign residual = next_crc ^ TAIL_DELTA[count_ff];

   always_comb begin
      mode_in  = mode_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         mode_in  = csr_write_data;
         crc_in   = CRC_PRESET;
         count_in = '0;
      end else if (finish) begin
         crc_in   = CRC_PRESET;
         count_in = '0;
      end else if (s1_take) begin
         crc_in = next_crc;
         if (mode_ff && (count_ff != COUNT_W'(TAIL_BYTES - 1))) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         crc_ff       <= CRC_PRESET;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         if (mode_ff) begin
            out_data_ff.crc_value <= ~residual;
            out_data_ff.crc_error <= (residual != 32'h0);
         end else begin
            out_data_ff.crc_value <= ~next_crc;
            out_data_ff.crc_error <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/crc32_generate_check_top.sv -----
// Top level of the CRC-32 generate/check block: one byte per cycle, MSB first.
// An accepted final byte passes the input register, then the result register, to rsp_.
// Throughput: one byte per cycle, set by the combinational eight-bit CRC update.
// A result waiting under rsp_stall holds only the next final byte; other bytes still flow.
// Reset (synchronous, active high) selects generate mode and presets the register to ones.
`default_nettype none

module crc32_generate_check_top
   import crc32gc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    s1_valid;
   req_type s1_data;
   logic    s1_take;

   crc32gc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .s1_take   (s1_take)
   );

   crc32gc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .s1_valid         (s1_valid),
      .s1_data          (s1_data),
      .s1_take          (s1_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

`ifndef ASSERT_OFF
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid)
      else $error("Input stalled with an empty input register.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_data.last_byte && rsp_valid && rsp_stall) |-> !s1_take)
      else $error("Final byte taken while a result transaction was still waiting.");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_take && s1_data.last_byte) |=> rsp_valid)
      else $error("Final byte did not produce a result transaction.");
`endif

endmodule

`default_nettype wire
